// ----- rtl/core/sliding_window_median_filter_unit_assert.svh -----
// Assertion macros for the sliding window median filter checker.
// Needs nothing else; included by the checker file.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SWMF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swmf checker: same-cycle property failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SWMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swmf checker: next-cycle property failed");

`endif

// ----- rtl/core/swmf_pkg.sv -----
// Shared types and constants of the sliding window median filter.
// No dependencies; used by swmf_cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package swmf_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int TIME_WIDTH  = 32;
   localparam int WS_WIDTH    = 5;
   localparam logic [WS_WIDTH-1:0] WS_RESET = 5'd5;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [TIME_WIDTH-1:0]         stamp_type;

   // per-cycle control broadcast to every cell of the chain
   typedef struct packed {
      logic shift;   // take neighbor's sample, clear rank
      logic scan;    // compare against probe, update rank
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/sliding_window_median_filter_unit.sv -----
// Sliding window median filter: a request is taken while idle; when the window is
// full a rank scan over the first k cells runs, one probe cell per cycle,
// then a final state selects the median into the output register once the last
// result has been taken, and requests are taken again (it stays idle if none is due).
// Synchronous active-high reset empties the window and sets window_size to 5;
// sample cells are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_filter_unit #(
   parameter int WINDOW_MAX = 16
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire signed [swmf_pkg::VALUE_WIDTH-1:0]  req_sample_value,
   input  wire [swmf_pkg::TIME_WIDTH-1:0]          req_sample_time,
   input  wire                                     req_start_new,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic signed [swmf_pkg::VALUE_WIDTH-1:0] rsp_median_value,
   output logic [swmf_pkg::TIME_WIDTH-1:0]         rsp_median_time,
   input  wire                                     csr_write_enable,
   input  wire [swmf_pkg::WS_WIDTH-1:0]            csr_write_data
);

   localparam int IW = $clog2(WINDOW_MAX);
   localparam int KW = $clog2(WINDOW_MAX + 1);
   localparam int CW = (KW > swmf_pkg::WS_WIDTH) ? KW : swmf_pkg::WS_WIDTH;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [swmf_pkg::WS_WIDTH-1:0] ws_ff, ws_in;
   logic [KW-1:0]                 fill_ff, fill_in;
   logic [KW-1:0]                 k_ff, k_in;
   logic [IW-1:0]                 scan_idx_ff, scan_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   swmf_pkg::value_type           rsp_value_ff, rsp_value_in;
   swmf_pkg::stamp_type           rsp_time_ff, rsp_time_in;

   logic [CW-1:0]                 ws_ext;
   logic [CW-1:0]                 k_sel;
   logic [KW-1:0]                 k_eff;
   logic [KW-1:0]                 fill_base;
   logic [KW-1:0]                 fill_next;
   logic [KW-1:0]                 mid_rank;
   logic [KW-1:0]                 time_pos;
   logic [IW-1:0]                 last_idx;
   logic                          req_accept;
   logic                          rsp_load;
   swmf_pkg::cell_ctrl_type       ctrl;
   swmf_pkg::value_type           probe_value;
   swmf_pkg::value_type           sel_value;

   swmf_pkg::value_type           cell_value [WINDOW_MAX];
   swmf_pkg::stamp_type           cell_time  [WINDOW_MAX];
   logic [IW-1:0]                 cell_rank  [WINDOW_MAX];

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_load   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // effective window size: zero acts as one, clipped to the chain length
   always_comb begin
      ws_ext = CW'(ws_ff);
      if (ws_ext == '0) begin
         k_sel = CW'(1);
      end else if (ws_ext > CW'(WINDOW_MAX)) begin
         k_sel = CW'(WINDOW_MAX);
      end else begin
         k_sel = ws_ext;
      end
      k_eff = k_sel[KW-1:0];
   end

   // fill count after this request, saturating at the chain length
   assign fill_base = req_start_new ? '0 : fill_ff;
   assign fill_next = (fill_base < KW'(WINDOW_MAX)) ? (fill_base + KW'(1)) : fill_base;

   assign mid_rank = k_ff >> 1;
   assign time_pos = (k_ff - KW'(1)) - (k_ff >> 1);
   assign last_idx = IW'(k_ff - KW'(1));

   // cell control
   assign ctrl.shift  = req_accept;
   assign ctrl.scan   = (state_ff == ST_SCAN);
   assign probe_value = cell_value[scan_idx_ff];

   // chain of cells, newest sample in cell 0
   for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
      if (g == 0) begin : g_head
         swmf_cell #(.IDX_WIDTH(IW), .CELL_IDX(g)) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .prev_value  (req_sample_value),
            .prev_time   (req_sample_time),
            .probe_value (probe_value),
            .probe_idx   (scan_idx_ff),
            .cell_value  (cell_value[g]),
            .cell_time   (cell_time[g]),
            .cell_rank   (cell_rank[g])
         );
      end else begin : g_body
         swmf_cell #(.IDX_WIDTH(IW), .CELL_IDX(g)) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .prev_value  (cell_value[g-1]),
            .prev_time   (cell_time[g-1]),
            .probe_value (probe_value),
            .probe_idx   (scan_idx_ff),
            .cell_value  (cell_value[g]),
            .cell_time   (cell_time[g]),
            .cell_rank   (cell_rank[g])
         );
      end
   end

   // median pick: the active cell whose rank is k/2
   always_comb begin
      sel_value = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if ((KW'(i) < k_ff) && (KW'(cell_rank[i]) == mid_rank)) begin
            sel_value = sel_value | cell_value[i];
         end
      end
   end

   // control and output register next state
   always_comb begin
      state_in     = state_ff;
      ws_in        = ws_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      scan_idx_in  = scan_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_time_in  = rsp_time_ff;

      if (csr_write_enable) begin
         ws_in = csr_write_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               fill_in     = fill_next;
               k_in        = k_eff;
               scan_idx_in = '0;
               if (fill_next >= k_eff) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            scan_idx_in = scan_idx_ff + IW'(1);
            if (scan_idx_ff == last_idx) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = sel_value;
               rsp_time_in  = cell_time[time_pos[IW-1:0]];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ws_ff        <= swmf_pkg::WS_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      scan_idx_ff  <= scan_idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_time_ff  <= rsp_time_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = rsp_value_ff;
   assign rsp_median_time  = rsp_time_ff;

endmodule

`default_nettype wire

// ----- rtl/core/swmf_cell.sv -----
// One cell of the window chain: holds a sample and its running rank.
// Depends on swmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swmf_cell #(
   parameter int IDX_WIDTH = 4,
   parameter int CELL_IDX  = 0
) (
   input  wire                         clock,
   input  swmf_pkg::cell_ctrl_type     ctrl,
   input  swmf_pkg::value_type         prev_value,
   input  swmf_pkg::stamp_type         prev_time,
   input  swmf_pkg::value_type         probe_value,
   input  wire [IDX_WIDTH-1:0]         probe_idx,
   output swmf_pkg::value_type         cell_value,
   output swmf_pkg::stamp_type         cell_time,
   output logic [IDX_WIDTH-1:0]        cell_rank
);

   localparam logic [IDX_WIDTH-1:0] MY_IDX = IDX_WIDTH'(CELL_IDX);

   swmf_pkg::value_type    value_ff, value_in;
   swmf_pkg::stamp_type    time_ff, time_in;
   logic [IDX_WIDTH-1:0]   rank_ff, rank_in;
   logic                   probe_below;

   // probe sorts ahead of this cell; ties broken by cell position
   assign probe_below = (probe_value < value_ff) ||
                        ((probe_value == value_ff) && (probe_idx < MY_IDX));

   // sample shift and rank count
   always_comb begin
      value_in = value_ff;
      time_in  = time_ff;
      rank_in  = rank_ff;
      if (ctrl.shift) begin
         value_in = prev_value;
         time_in  = prev_time;
         rank_in  = '0;
      end else if (ctrl.scan && probe_below) begin
         rank_in = rank_ff + IDX_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      time_ff  <= time_in;
      rank_ff  <= rank_in;
   end

   assign cell_value = value_ff;
   assign cell_time  = time_ff;
   assign cell_rank  = rank_ff;

endmodule

`default_nettype wire

// ----- rtl/core/swmf_checker.sv -----
// Port-level checker for the sliding window median filter, bound to the top level.
// Depends on swmf_pkg and sliding_window_median_filter_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_median_filter_unit_assert.svh"

module swmf_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_ready,
   input wire                              rsp_valid,
   input wire                              rsp_ready,
   input wire [swmf_pkg::VALUE_WIDTH-1:0]  rsp_median_value,
   input wire [swmf_pkg::TIME_WIDTH-1:0]   rsp_median_time
);

   // reset leaves no result pending and the request side open
   `SWMF_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid && req_ready)

   // a result is only loaded at the end of a scan, when requests are held off
   `SWMF_ASSERT_NOW(a_load_while_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))

   // the request that completes a window never yields its result in the next cycle
   `SWMF_ASSERT_NEXT(a_no_instant_result, clock, reset, req_valid && req_ready,
      !$rose(rsp_valid))

   // a stalled result holds
   `SWMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_median_value) && $stable(rsp_median_time))

endmodule

bind sliding_window_median_filter_unit swmf_checker u_swmf_checker (.*);

`default_nettype wire
